[sv/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg: shared types, codes and round functions
// S-box tables, GF(2^8) helpers and the byte-level AES round transforms.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int MaxRounds = 14;
	localparam int NumKeys   = MaxRounds + 1;
	localparam int BlockW    = 128;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_ENC  = 2'd1;
	localparam logic [1:0] ACT_DEC  = 2'd2;

	localparam logic [3:0] RC_RESET = 4'd10;

	typedef struct packed {
		logic              valid;
		logic              dec;
		logic [BlockW-1:0] data;
	} stage_t;

	typedef struct packed {
		logic enc_act;
		logic enc_last;
		logic dec_act;
		logic dec_mix;
	} round_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// multiply by a small constant (at most 15)
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] acc;
		logic [7:0] p;
		acc = 8'h00;
		p   = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) acc = acc ^ p;
			p = xtime(p);
		end
		return acc;
	endfunction

	function automatic logic [7:0] get_byte(input logic [BlockW-1:0] x, input int i);
		return x[BlockW-1-8*i -: 8];
	endfunction

	function automatic logic [BlockW-1:0] byte_sub(input logic [BlockW-1:0] x);
		logic [BlockW-1:0] y;
		for (int i = 0; i < 16; i++) y[BlockW-1-8*i -: 8] = SBOX[get_byte(x, i)];
		return y;
	endfunction

	function automatic logic [BlockW-1:0] byte_sub_inv(input logic [BlockW-1:0] x);
		logic [BlockW-1:0] y;
		for (int i = 0; i < 16; i++) y[BlockW-1-8*i -: 8] = INV_SBOX[get_byte(x, i)];
		return y;
	endfunction

	// rotate row r left by r (forward) or right by r (inverse)
	function automatic logic [BlockW-1:0] row_rotate(input logic [BlockW-1:0] x,
		input logic inv);
		logic [BlockW-1:0] y;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				y[BlockW-1-8*(4*c+r) -: 8] = inv ? get_byte(x, 4*((c+3*r)%4)+r)
					: get_byte(x, 4*((c+r)%4)+r);
			end
		end
		return y;
	endfunction

	function automatic logic [BlockW-1:0] column_mix(input logic [BlockW-1:0] x,
		input logic inv);
		logic [BlockW-1:0] y;
		logic [3:0]        m [4];
		logic [7:0]        acc;
		if (inv) m = '{4'd14, 4'd11, 4'd13, 4'd9};
		else     m = '{4'd2, 4'd3, 4'd1, 4'd1};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int j = 0; j < 4; j++) acc = acc ^ gmul(get_byte(x, 4*c+j), m[(4+j-r)%4]);
				y[BlockW-1-8*(4*c+r) -: 8] = acc;
			end
		end
		return y;
	endfunction

endpackage

[sv/aes_if.sv]
// ----------------------------------------------------------------------------
// aes_req_if / aes_rsp_if: request and result channels
// Valid/ready channels carrying one request or one result block.
// ----------------------------------------------------------------------------
interface aes_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  key_slot;
	logic [63:0] data_high;
	logic [63:0] data_low;

	modport source (output valid, action, key_slot, data_high, data_low, input ready);
	modport sink   (input valid, action, key_slot, data_high, data_low, output ready);
endinterface

interface aes_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink   (input valid, result_high, result_low, output ready);
endinterface

[sv/aes_block_cipher.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher: pipelined AES encrypt/decrypt core
// Pipeline: a key add stage plus 14 round stages from request to result.
// Throughput: one encrypt or decrypt request per cycle; a result stall holds all stages.
// A key load waits until the pipeline has drained, then writes its key slot.
// Reset clears all valid bits and sets the round count to 10; round keys are not reset.
// ----------------------------------------------------------------------------
module aes_block_cipher (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_wdata,
	aes_req_if.sink         req,
	aes_rsp_if.source       rsp
);

	localparam int NR = aes_pkg::MaxRounds;

	logic [3:0]                 rc_q;
	logic [3:0]                 nr;
	logic                       adv;
	logic                       busy;
	logic                       load_req;
	logic                       blk_req;
	logic [aes_pkg::BlockW-1:0] key [aes_pkg::NumKeys];
	logic [aes_pkg::BlockW-1:0] key_first;
	logic [aes_pkg::BlockW-1:0] blk_in;
	aes_pkg::stage_t            st_s [NR+1];
	aes_pkg::round_ctl_t        ctl [NR+1];
	logic [NR:0]                valid_vec;

	// Round count register; out-of-range counts clamp to 1 or the max.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= aes_pkg::RC_RESET;
		end else if (cfg_we) begin
			rc_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (rc_q == 4'd0)          nr = 4'd1;
		else if (rc_q > 4'(NR))    nr = 4'(NR);
		else                       nr = rc_q;
	end

	// The whole pipeline advances together; hold everything while the
	// last stage has a result that the sink has not taken.
	assign adv = !st_s[NR].valid || rsp.ready;

	always_comb begin
		for (int i = 0; i <= NR; i++) valid_vec[i] = st_s[i].valid;
	end
	assign busy = |valid_vec;

	// A load request must not overtake blocks still reading the old keys.
	assign req.ready = adv && !(req.action == aes_pkg::ACT_LOAD && busy);
	assign load_req  = req.valid && req.ready && req.action == aes_pkg::ACT_LOAD;
	assign blk_req   = req.valid && req.ready &&
		(req.action == aes_pkg::ACT_ENC || req.action == aes_pkg::ACT_DEC);
	assign blk_in    = {req.data_high, req.data_low};

	aes_key_store u_keys (
		.clk     (clk),
		.we      (load_req),
		.slot    (req.key_slot),
		.wdata   (blk_in),
		.sel     ((req.action == aes_pkg::ACT_DEC) ? nr : 4'd0),
		.key     (key),
		.key_sel (key_first)
	);

	// Stage 0: initial key add (key 0 to encrypt, key nr to decrypt).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s[0].valid <= 1'b0;
		end else if (adv) begin
			st_s[0].valid <= blk_req;
			st_s[0].dec   <= (req.action == aes_pkg::ACT_DEC);
			st_s[0].data  <= blk_in ^ key_first;
		end
	end

	assign ctl[0] = '0;

	// Stage p runs encrypt round p with key p, or decrypt round 15-p with
	// key 14-p; rounds beyond the count pass the block through unchanged.
	for (genvar p = 1; p <= NR; p++) begin : g_round
		assign ctl[p].enc_act  = 4'(p) <= nr;
		assign ctl[p].enc_last = 4'(p) == nr;
		assign ctl[p].dec_act  = 4'(NR + 1 - p) <= nr;
		assign ctl[p].dec_mix  = p < NR;

		aes_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl     (ctl[p]),
			.enc_key (key[p]),
			.dec_key (key[NR - p]),
			.din     (st_s[p-1]),
			.dout    (st_s[p])
		);
	end

	assign rsp.valid       = st_s[NR].valid;
	assign rsp.result_high = st_s[NR].data[aes_pkg::BlockW-1 -: 64];
	assign rsp.result_low  = st_s[NR].data[63:0];

endmodule

[sv/aes_key_store.sv]
// ----------------------------------------------------------------------------
// aes_key_store: round key registers
// Holds the loaded round keys; one selectable read for the initial key add.
// ----------------------------------------------------------------------------
module aes_key_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [3:0]                 slot,
	input  logic [aes_pkg::BlockW-1:0] wdata,
	input  logic [3:0]                 sel,
	output logic [aes_pkg::BlockW-1:0] key [aes_pkg::NumKeys],
	output logic [aes_pkg::BlockW-1:0] key_sel
);

	logic [aes_pkg::BlockW-1:0] key_q [aes_pkg::NumKeys];

	// drop loads to slots beyond the last round
	always_ff @(posedge clk) begin
		if (we && slot <= 4'(aes_pkg::MaxRounds)) key_q[slot] <= wdata;
	end

	assign key     = key_q;
	assign key_sel = key_q[sel];

endmodule

[sv/aes_round.sv]
// ----------------------------------------------------------------------------
// aes_round: one pipelined cipher round
// Forward or inverse round with bypass for rounds beyond the round count.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  aes_pkg::round_ctl_t        ctl,
	input  logic [aes_pkg::BlockW-1:0] enc_key,
	input  logic [aes_pkg::BlockW-1:0] dec_key,
	input  aes_pkg::stage_t            din,
	output aes_pkg::stage_t            dout
);

	aes_pkg::stage_t            pipe_s;
	logic [aes_pkg::BlockW-1:0] enc_d, dec_d, nxt;

	always_comb begin
		enc_d = aes_pkg::row_rotate(aes_pkg::byte_sub(din.data), 1'b0);
		if (!ctl.enc_last) enc_d = aes_pkg::column_mix(enc_d, 1'b0);
		enc_d = enc_d ^ enc_key;

		dec_d = aes_pkg::byte_sub_inv(aes_pkg::row_rotate(din.data, 1'b1)) ^ dec_key;
		if (ctl.dec_mix) dec_d = aes_pkg::column_mix(dec_d, 1'b1);

		if (din.dec) nxt = ctl.dec_act ? dec_d : din.data;
		else         nxt = ctl.enc_act ? enc_d : din.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s.valid <= 1'b0;
		end else if (adv) begin
			pipe_s.valid <= din.valid;
			pipe_s.dec   <= din.dec;
			pipe_s.data  <= nxt;
		end
	end

	assign dout = pipe_s;

endmodule
